// ===== hw/rtl/bfa_pkg.sv =====
// Shared constants, codes and types of the bitmap frame allocator.
package bfa_pkg;

  // Field widths of the items and registers.
  localparam int unsigned FRAME_W = 21;
  localparam int unsigned BASE_W  = 20;
  localparam int unsigned COUNT_W = 11;

  // Default number of frames the used map can cover.
  localparam int unsigned FRAME_DEPTH_DEF = 1024;

  // Reset value of the frame count register.
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  // The used map is stored as words of this many bits.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORD_BITS = 5;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = BASE_W;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  // Item kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Answer of the clear-bit search over one map word.
  typedef struct packed {
    logic                 found;
    logic [WORD_BITS-1:0] pos;
  } zf_res_t;

endpackage

// ===== hw/rtl/bfa_if.sv =====
// Request and response channels of the bitmap frame allocator.
interface bfa_req_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FRAME_W-1:0] frame_number;
  logic               auto_pick;

  modport source (output valid, kind, frame_number, auto_pick, input ready);
  modport sink (input valid, kind, frame_number, auto_pick, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] result_frame;
  logic               error;
  logic [COUNT_W-1:0] left_count;

  modport source (output valid, result_frame, error, left_count, input ready);
  modport sink (input valid, result_frame, error, left_count, output ready);
endinterface

// ===== hw/rtl/bfa_zero_find.sv =====
// Search unit: lowest clear bit of one map word at or above a start position.
module bfa_zero_find import bfa_pkg::*; (
  input  logic [WORD_W-1:0]    word_i,
  input  logic [WORD_BITS-1:0] start_i,
  output zf_res_t              res_o
);

  logic [WORD_W-1:0] masked;

  // Bits below the start position count as used.
  assign masked = word_i | ((WORD_W'(1) << start_i) - WORD_W'(1));

  // Priority encoder toward the lowest clear bit.
  always_comb begin
    res_o.found = 1'b0;
    res_o.pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        res_o.found = 1'b1;
        res_o.pos   = WORD_BITS'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// An accepted item is checked; an error goes straight to the done step, a normal item first
// updates its 32-bit map word. An allocate that takes the hint frame then scans later words,
// up to 31 further ones at the default depth; the search unit looks at one word per cycle.
// The result is registered once the output is free, and only then is the next item accepted.
// Reset clears per-word valid flags at once, so the used map reads as all clear with no sweep.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bfa_req_if.sink               req_i,
  bfa_rsp_if.source             rsp_o
);

  // The frame count register cannot exceed this, so neither can the map size.
  localparam int unsigned MAX_CNT  = (1 << COUNT_W) - 1;
  localparam int unsigned MAX_SIZE = (FRAME_DEPTH < MAX_CNT) ? FRAME_DEPTH : MAX_CNT;
  localparam int unsigned SZ_W     = $clog2(MAX_SIZE + 1);
  localparam int unsigned ROWS     = (MAX_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned RA_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned POS_W    = $clog2(ROWS * WORD_W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [BASE_W-1:0]  base_q;
  logic [COUNT_W-1:0] count_q;
  logic               kind_q;
  logic [FRAME_W-1:0] frame_q;
  logic               auto_q;
  logic [SZ_W-1:0]    idx_q, idx_d;
  logic               err_q, err_d;
  logic [SZ_W-1:0]    used_q, used_d;
  logic [SZ_W-1:0]    hint_q, hint_d;
  logic [RA_W-1:0]    row_q, row_d;

  logic               out_valid_q, out_valid_d;
  logic [FRAME_W-1:0] out_frame_q;
  logic               out_err_q;
  logic [COUNT_W-1:0] out_left_q;
  logic               out_load;

  logic [WORD_W-1:0]  mem [ROWS];
  logic [ROWS-1:0]    row_vld_q;
  logic [WORD_W-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic               rd_en;
  logic [RA_W-1:0]    rd_addr;
  logic               mem_we;
  logic [RA_W-1:0]    wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic [SZ_W-1:0]    size;
  logic [FRAME_W:0]   offset;
  logic               off_ok;
  logic               accept;

  logic [WORD_W-1:0]    row_word;
  logic [WORD_W-1:0]    bit_mask;
  logic [WORD_W-1:0]    mod_word;
  logic [WORD_BITS-1:0] bit_pos;
  logic [WORD_W-1:0]    zf_word;
  logic [WORD_BITS-1:0] zf_start;
  zf_res_t              zf_res;
  logic [RA_W-1:0]      cur_row;
  logic [POS_W-1:0]     cand;
  logic [POS_W-1:0]     next_start;
  logic [POS_W-1:0]     size_p;

  // Effective map size and the range check of the named frame.
  assign size = (32'(count_q) < 32'(MAX_SIZE)) ? SZ_W'(count_q) : SZ_W'(MAX_SIZE);
  assign offset = {1'b0, frame_q} - {2'b0, base_q};
  assign off_ok = !offset[FRAME_W] && (offset[FRAME_W-1:0] < FRAME_W'(size));

  assign accept        = req_i.valid && req_i.ready;
  assign req_i.ready   = (state_q == S_IDLE);

  // Read-modify-write of the addressed map word.
  assign row_word = rd_vld_q ? rd_data_q : '0;
  assign bit_pos  = WORD_BITS'(idx_q);
  assign bit_mask = WORD_W'(1) << bit_pos;
  assign mod_word = (kind_q == KIND_ALLOC) ? (row_word | bit_mask) : (row_word & ~bit_mask);

  // The search unit looks at the modified word first, then at each later word read.
  assign cur_row  = (state_q == S_SCAN) ? row_q : RA_W'(idx_q >> WORD_BITS);
  assign zf_word  = (state_q == S_SCAN) ? row_word : mod_word;
  assign zf_start = (state_q == S_SCAN) ? '0 : bit_pos;

  bfa_zero_find u_zero_find (
    .word_i  (zf_word),
    .start_i (zf_start),
    .res_o   (zf_res)
  );

  assign cand       = (POS_W'(cur_row) << WORD_BITS) | POS_W'(zf_res.pos);
  assign next_start = (POS_W'(cur_row) + POS_W'(1)) << WORD_BITS;
  assign size_p     = POS_W'(size);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    err_d    = err_q;
    used_d   = used_q;
    hint_d   = hint_q;
    row_d    = row_q;
    rd_en    = 1'b0;
    rd_addr  = cur_row;
    mem_we   = 1'b0;
    wr_addr  = RA_W'(idx_q >> WORD_BITS);
    wr_data  = mod_word;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (kind_q == KIND_ALLOC) begin
          if (used_q >= size) begin
            err_d = 1'b1;
          end else if (auto_q) begin
            err_d = (hint_q >= size);
          end else begin
            err_d = !off_ok;
          end
          idx_d = auto_q ? hint_q : SZ_W'(offset[FRAME_W-1:0]);
        end else begin
          err_d = !off_ok;
          idx_d = SZ_W'(offset[FRAME_W-1:0]);
        end
        if (err_d) begin
          idx_d   = '0;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = RA_W'(idx_d >> WORD_BITS);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        mem_we = 1'b1;
        if (kind_q == KIND_FREE) begin
          used_d  = (used_q != '0) ? used_q - SZ_W'(1) : used_q;
          hint_d  = (idx_q < hint_q) ? idx_q : hint_q;
          state_d = S_DONE;
        end else begin
          used_d = used_q + SZ_W'(1);
          if (idx_q != hint_q) begin
            state_d = S_DONE;
          end else if (zf_res.found) begin
            hint_d  = (cand < size_p) ? SZ_W'(cand) : size;
            state_d = S_DONE;
          end else if (next_start >= size_p) begin
            hint_d  = size;
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cur_row + RA_W'(1);
            row_d   = cur_row + RA_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (zf_res.found) begin
          hint_d  = (cand < size_p) ? SZ_W'(cand) : size;
          state_d = S_DONE;
        end else if (next_start >= size_p) begin
          hint_d  = size;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_row + RA_W'(1);
          row_d   = cur_row + RA_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      count_q     <= COUNT_RST;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == REG_BASE_FRAME)) begin
        base_q <= cfg_wdata_i[BASE_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_FRAME_COUNT)) begin
        count_q <= cfg_wdata_i[COUNT_W-1:0];
      end
      if (mem_we) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= req_i.kind;
      frame_q <= req_i.frame_number;
      auto_q  <= req_i.auto_pick;
    end
    idx_q <= idx_d;
    err_q <= err_d;
    row_q <= row_d;
    if (out_load) begin
      out_err_q   <= err_q;
      out_frame_q <= err_q ? '0 : ({1'b0, base_q} + FRAME_W'(idx_q));
      out_left_q  <= (used_q >= size) ? '0 : COUNT_W'(size - used_q);
    end
  end

  // Used map words.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_frame = out_frame_q;
  assign rsp_o.error        = out_err_q;
  assign rsp_o.left_count   = out_left_q;

`ifndef ASSERT_OFF
  // An accepted item always starts with the check step.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CHECK))
    else $error("accepted item did not enter the check step");

  // The scan is only reached from the map update or from itself.
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($past(state_q) == S_MOD || $past(state_q) == S_SCAN))
    else $error("scan entered from an unexpected step");

  // An error result never carries a frame number.
  a_err_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.error) |-> (rsp_o.result_frame == '0))
    else $error("error result carries a frame number");

  // The used count never passes the largest possible map size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MAX_SIZE))
    else $error("used count out of bounds");
`endif

endmodule

// ===== bench/bfa_frame_checker.sv =====
`timescale 1ns / 1ps
// Response checker of the frame allocator: it tracks the used map, predicts and compares.
module bfa_frame_checker import bfa_pkg::*; #(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bfa_req_if                    req_i,
  bfa_rsp_if                    rsp_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           error_seen_o,
  output int unsigned           cfg_writes_o
);

  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic               error;
    logic [COUNT_W-1:0] left_count;
  } frame_result_t;

  // Shadow copy of the registers and of the allocator state.
  logic [BASE_W-1:0]  base_frame_q;
  logic [COUNT_W-1:0] frame_count_q;
  bit                 used_map_q [FRAME_DEPTH];
  logic [COUNT_W-1:0] used_total_q;
  logic [COUNT_W-1:0] next_free_q;

  // Results still owed by the block, oldest first.
  frame_result_t frame_results_q [$];

  // Applies one request to the shadow state and returns the response it should produce.
  function automatic frame_result_t frame_step(logic kind, logic [FRAME_W-1:0] frame,
                                               logic auto_pick);
    int unsigned   span;
    int unsigned   idx;
    int unsigned   scan;
    logic          named_ok;
    logic          fail;
    frame_result_t res;
    span = (frame_count_q < FRAME_DEPTH) ? frame_count_q : FRAME_DEPTH;
    // A named frame maps to an index only inside [base, base + span).
    named_ok = (frame >= base_frame_q) && (frame - base_frame_q < span);
    idx      = named_ok ? frame - base_frame_q : 0;
    fail     = 1'b0;
    if (kind == KIND_ALLOC) begin
      if (used_total_q >= span) begin
        fail = 1'b1;
      end else if (auto_pick) begin
        idx  = next_free_q;
        fail = (idx >= span);
      end else begin
        fail = !named_ok;
      end
      if (!fail) begin
        used_map_q[idx] = 1'b1;
        used_total_q++;
        // Taking the hint frame walks the hint up to the next clear bit or the end.
        if (idx == next_free_q) begin
          scan = idx;
          while (scan < span && used_map_q[scan]) scan++;
          next_free_q = COUNT_W'(scan);
        end
      end
    end else begin
      fail = !named_ok;
      if (!fail) begin
        used_map_q[idx] = 1'b0;
        if (used_total_q != 0) used_total_q--;
        if (idx < next_free_q) next_free_q = COUNT_W'(idx);
      end
    end
    res.result_frame = fail ? '0 : FRAME_W'(base_frame_q + idx);
    res.error        = fail;
    res.left_count   = (used_total_q >= span) ? '0 : COUNT_W'(span - used_total_q);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: response mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      base_frame_q  = '0;
      frame_count_q = COUNT_RST;
      foreach (used_map_q[i]) used_map_q[i] = 1'b0;
      used_total_q  = '0;
      next_free_q   = '0;
      frame_results_q.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      error_seen_o  = 0;
      cfg_writes_o  = 0;
    end else begin
      // Responses first: one taken in this cycle belongs to an earlier request.
      if (rsp_i.valid && rsp_i.ready) begin
        checked_o++;
        if (frame_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item, frame %0d error %0b left %0d",
                                    rsp_i.result_frame, rsp_i.error, rsp_i.left_count));
        end else begin
          want = frame_results_q.pop_front();
          if (rsp_i.result_frame !== want.result_frame)
            report_mismatch($sformatf("result_frame %0d, expected %0d",
                                      rsp_i.result_frame, want.result_frame));
          if (rsp_i.error !== want.error)
            report_mismatch($sformatf("error %0b, expected %0b", rsp_i.error, want.error));
          if (rsp_i.left_count !== want.left_count)
            report_mismatch($sformatf("left_count %0d, expected %0d",
                                      rsp_i.left_count, want.left_count));
        end
      end
      // Requests are predicted in the order the block takes them.
      if (req_i.valid && req_i.ready) begin
        want = frame_step(req_i.kind, req_i.frame_number, req_i.auto_pick);
        if (want.error) error_seen_o++;
        frame_results_q.push_back(want);
      end
      // Register writes leave the map and the counters alone.
      if (cfg_we_i) begin
        cfg_writes_o++;
        case (cfg_idx_i)
          REG_BASE_FRAME:  base_frame_q  = cfg_wdata_i[BASE_W-1:0];
          REG_FRAME_COUNT: frame_count_q = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = frame_results_q.size();
  end

endmodule

// ===== bench/tb_bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// Top of the frame allocator testbench: clock, reset, request and register stimulus, verdict.
module tb_bitmap_frame_allocator import bfa_pkg::*; ();

  localparam int unsigned FRAME_TOP = 1049599;
  localparam logic [FRAME_W-1:0] HIGH_BASE = 21'h0FFFFF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    idle_on  = 1'b1;
  bit                    stall_on = 1'b1;
  int unsigned           fail_cnt;
  int unsigned           pending_cnt;
  int unsigned           checked_cnt;
  int unsigned           error_cnt;
  int unsigned           cfg_cnt;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_frame_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  bfa_frame_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt),
    .checked_o    (checked_cnt),
    .error_seen_o (error_cnt),
    .cfg_writes_o (cfg_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Response side: ready drops low at random while stalls are enabled.
  initial begin : rsp_stall
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Presents one request, after an optional idle burst, and waits until it is taken.
  task automatic send_request(logic kind, logic [FRAME_W-1:0] frame, logic auto_pick);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.frame_number <= frame;
    req_ch.auto_pick    <= auto_pick;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Holds requests back until every outstanding response has been checked.
  task automatic drain_responses();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_responses();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One register setting followed by random requests, mostly aimed inside the managed range.
  task automatic run_phase(logic [BASE_W-1:0] base, logic [COUNT_W-1:0] count,
                           int unsigned n_items, bit busy, bit mid_pause);
    int unsigned        span_now;
    int unsigned        pick;
    logic [FRAME_W-1:0] frame;
    write_reg(REG_BASE_FRAME, CFG_DATA_W'(base));
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(count));
    idle_on  = busy;
    stall_on = busy;
    span_now = (count < FRAME_DEPTH_DEF) ? count : FRAME_DEPTH_DEF;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (mid_pause && k == n_items / 2) drain_responses();
      pick = $urandom_range(0, 99);
      if (span_now == 0 || pick < 8) begin
        frame = FRAME_W'($urandom_range(0, FRAME_TOP));
      end else if (pick < 18) begin
        // Frames on and just past both ends of the range.
        case ($urandom_range(0, 3))
          0:       frame = (base == 0) ? '0 : FRAME_W'(base - 1);
          1:       frame = FRAME_W'(base + span_now);
          2:       frame = FRAME_W'(base);
          default: frame = FRAME_W'(base + span_now - 1);
        endcase
      end else begin
        frame = FRAME_W'(base + $urandom_range(0, span_now - 1));
      end
      send_request($urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC, frame,
                   logic'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_BASE_FRAME;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_ALLOC;
    req_ch.frame_number = '0;
    req_ch.auto_pick    = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: auto and named allocation, double claim, double free, ranges.
    send_request(KIND_ALLOC, '0, 1'b1);
    send_request(KIND_ALLOC, FRAME_W'(FRAME_TOP), 1'b0);
    send_request(KIND_ALLOC, 21'd1023, 1'b0);
    send_request(KIND_ALLOC, 21'd1023, 1'b0);
    send_request(KIND_FREE, 21'd1023, 1'b0);
    send_request(KIND_FREE, 21'd1023, 1'b1);
    send_request(KIND_FREE, 21'd0, 1'b0);
    send_request(KIND_FREE, 21'd0, 1'b0);
    send_request(KIND_FREE, 21'd1024, 1'b0);

    // Highest base with a small map: below base, half fill, then free frames above the hint.
    write_reg(REG_BASE_FRAME, CFG_DATA_W'(HIGH_BASE));
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(8));
    send_request(KIND_ALLOC, 21'd0, 1'b0);
    repeat (4) send_request(KIND_ALLOC, '0, 1'b1);
    send_request(KIND_FREE, HIGH_BASE + 21'd6, 1'b0);
    send_request(KIND_FREE, HIGH_BASE + 21'd7, 1'b0);

    // Shrink the map below the hint: stale hint, full store, top-edge free, hint scan.
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(3));
    send_request(KIND_ALLOC, '0, 1'b1);
    send_request(KIND_ALLOC, HIGH_BASE + 21'd2, 1'b0);
    send_request(KIND_ALLOC, '0, 1'b1);
    send_request(KIND_FREE, HIGH_BASE + 21'd3, 1'b0);
    send_request(KIND_FREE, HIGH_BASE + 21'd1, 1'b0);
    send_request(KIND_ALLOC, HIGH_BASE + 21'd1, 1'b0);

    // An empty map rejects everything.
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(0));
    send_request(KIND_ALLOC, '0, 1'b1);
    send_request(KIND_FREE, HIGH_BASE, 1'b0);

    // Random phases; the last one runs without any idling.
    run_phase(20'h12345, 11'd16, 200, 1'b1, 1'b0);
    run_phase(20'h00400, 11'd5, 150, 1'b1, 1'b0);
    run_phase(20'h00000, 11'd1, 100, 1'b1, 1'b0);
    run_phase(BASE_W'($urandom_range(0, 20'hFFFFF)), 11'd64, 200, 1'b1, 1'b1);
    run_phase(20'hFFFFF, 11'd1024, 200, 1'b1, 1'b0);
    run_phase(20'h00000, 11'd1024, 200, 1'b1, 1'b0);
    run_phase(BASE_W'($urandom_range(0, 20'hFFFFF)), 11'd40, 250, 1'b0, 1'b0);

    // Let any stray response surface after the last expected one.
    drain_responses();
    repeat (40) @(negedge clk_i);

    $display("Checked %0d responses, %0d predicted as errors, %0d register writes.",
             checked_cnt, error_cnt, cfg_cnt);
    $display("Map sizes 0 to 1024, bases up to 0xFFFFF, full, out-of-range, stale-hint cases.");
    if (fail_cnt == 0) begin
      $display("[bitmap_frame_allocator] OK");
    end else begin
      $display("[bitmap_frame_allocator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[bitmap_frame_allocator] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_zero_find.sv
hw/rtl/bitmap_frame_allocator.sv
bench/bfa_frame_checker.sv
bench/tb_bitmap_frame_allocator.sv
